### hw/rtl/d2q5_lattice_collision_assert.svh
// Assertion macros for the D2Q5 collision block.
// Used by d2q5_lattice_collision.sv; expects clk and rst_n in scope.
`ifndef D2Q5_LATTICE_COLLISION_ASSERT_SVH
`define D2Q5_LATTICE_COLLISION_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define D2Q5_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define D2Q5_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/d2q5_pkg.sv
// Package for the D2Q5 collision block: widths, register codes, payload types.
// No dependencies; imported by d2q5_relax and d2q5_lattice_collision.
package d2q5_pkg;

    localparam int FRAC_BITS = 16;

    localparam int POP_W  = 32;
    localparam int REST_W = 17;
    localparam int MW_W   = 17;
    localparam int TCS_W  = 18;
    localparam int KEEP_W = 18;
    localparam int MIX_W  = 18;

    // config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_REST_COEFF = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_WEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_THREE_C2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_FACTOR = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_MIX_FACTOR = CFG_IDX_W'(4);

    // reset values: 0.5, 1/6, 0.75, 0.0, 1.0
    localparam logic [REST_W-1:0] REST_COEFF_RST = REST_W'(1 << (FRAC_BITS - 1));
    localparam logic [MW_W-1:0]   MOVE_WEIGHT_RST = MW_W'(((1 << FRAC_BITS) + 3) / 6);
    localparam logic [TCS_W-1:0]  THREE_C2_RST = TCS_W'(3 << (FRAC_BITS - 2));
    localparam logic [KEEP_W-1:0] KEEP_FACTOR_RST = '0;
    localparam logic [MIX_W-1:0]  MIX_FACTOR_RST = MIX_W'(1 << FRAC_BITS);

    // datapath widths, all two's complement
    localparam int RHO_W  = POP_W + 3;                       // sum of five
    localparam int J_W    = POP_W + 1;                       // difference of two
    localparam int PR_W   = RHO_W + REST_W + 1;              // rest_coeff * rho
    localparam int PC_W   = RHO_W + TCS_W + 1;               // three_c2 * rho
    localparam int FEQ0_W = PR_W - FRAC_BITS;
    localparam int RP_W   = PC_W - FRAC_BITS;
    localparam int J3_W   = J_W + 2;                         // 3 * j
    localparam int T_W    = ((RP_W > J3_W) ? RP_W : J3_W) + 1;
    localparam int PM_W   = T_W + MW_W + 1;                  // move_weight * t
    localparam int FEQ_W  = PM_W - FRAC_BITS;
    localparam int KF_W   = KEEP_W + POP_W;
    localparam int MF_W   = FEQ_W + MIX_W + 1;
    localparam int ACC_W  = ((MF_W > KF_W) ? MF_W : KF_W) + 1;
    localparam int R_W    = ACC_W - FRAC_BITS;

    localparam int NUM_STAGES = 6;

    typedef struct packed {
        logic signed [POP_W-1:0] pop_rest;
        logic signed [POP_W-1:0] pop_east;
        logic signed [POP_W-1:0] pop_north;
        logic signed [POP_W-1:0] pop_west;
        logic signed [POP_W-1:0] pop_south;
    } pop_t;

    typedef struct packed {
        logic signed [POP_W-1:0] post_rest;
        logic signed [POP_W-1:0] post_east;
        logic signed [POP_W-1:0] post_north;
        logic signed [POP_W-1:0] post_west;
        logic signed [POP_W-1:0] post_south;
    } post_t;

    // load enables for the two relax stages
    typedef struct packed {
        logic mul;
        logic sum;
    } relax_en_t;

endpackage

### hw/rtl/d2q5_lattice_collision.sv
// D2Q5 BGK collision, one lattice cell per transfer, six register stages.
// Throughput 1 cell/cycle while post_ready does not stall the output.
// Each stage holds while the stage after it is full and stalled; bubbles fill.
// Reset clears stage valid bits and loads the config registers with defaults.
// Depends on d2q5_pkg, d2q5_relax and d2q5_lattice_collision_assert.svh.
`include "d2q5_lattice_collision_assert.svh"

module d2q5_lattice_collision (
    input  logic                                clk,
    input  logic                                rst_n,
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [d2q5_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [d2q5_pkg::CFG_DATA_W-1:0]     cfg_data,
    // cell populations in
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  d2q5_pkg::pop_t                      pop,
    // relaxed populations out
    output logic                                post_valid,
    input  logic                                post_ready,
    output d2q5_pkg::post_t                     post
);
    import d2q5_pkg::*;

    // Stage map:
    //   1: rho = sum of five, jx, jy
    //   2: rest_coeff*rho, three_c2*rho
    //   3: feq0 = floor(rest product), t = floor(three_c2 product) +/- 3j
    //   4: move_weight*t for the four moving directions
    //   5: keep*f and mix*feq (inside d2q5_relax)
    //   6: sum, floor, saturate (inside d2q5_relax), output register

    // ---------------- config registers ----------------
    logic        [REST_W-1:0] rest_coeff_reg;
    logic        [MW_W-1:0]   move_weight_reg;
    logic        [TCS_W-1:0]  three_c2_reg;
    logic signed [KEEP_W-1:0] keep_factor_reg;
    logic        [MIX_W-1:0]  mix_factor_reg;

    // Writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_coeff_reg  <= REST_COEFF_RST;
            move_weight_reg <= MOVE_WEIGHT_RST;
            three_c2_reg    <= THREE_C2_RST;
            keep_factor_reg <= KEEP_FACTOR_RST;
            mix_factor_reg  <= MIX_FACTOR_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_REST_COEFF:  rest_coeff_reg  <= cfg_data[REST_W-1:0];
                REG_MOVE_WEIGHT: move_weight_reg <= cfg_data[MW_W-1:0];
                REG_THREE_C2:    three_c2_reg    <= cfg_data[TCS_W-1:0];
                REG_KEEP_FACTOR: keep_factor_reg <= $signed(cfg_data[KEEP_W-1:0]);
                REG_MIX_FACTOR:  mix_factor_reg  <= cfg_data[MIX_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // A stage loads when it is empty or the stage after it moves on.
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] en;

    always_comb
    begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || post_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? pop_valid : vld_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign pop_ready  = en[0];
    assign post_valid = vld_reg[NUM_STAGES-1];

    // ---------------- stage 1: moments ----------------
    pop_t                    s1_pop_reg;
    logic signed [RHO_W-1:0] rho_reg;
    logic signed [J_W-1:0]   s1_jx_reg;
    logic signed [J_W-1:0]   s1_jy_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_pop_reg <= pop;
            rho_reg    <= RHO_W'($signed(pop.pop_rest)) + RHO_W'($signed(pop.pop_east))
                        + RHO_W'($signed(pop.pop_north)) + RHO_W'($signed(pop.pop_west))
                        + RHO_W'($signed(pop.pop_south));
            s1_jx_reg  <= J_W'($signed(pop.pop_east)) - J_W'($signed(pop.pop_west));
            s1_jy_reg  <= J_W'($signed(pop.pop_north)) - J_W'($signed(pop.pop_south));
        end
    end

    // ---------------- stage 2: density products ----------------
    pop_t                   s2_pop_reg;
    logic signed [PR_W-1:0] prod_rest_reg;
    logic signed [PC_W-1:0] prod_tcs_reg;
    logic signed [J_W-1:0]  s2_jx_reg;
    logic signed [J_W-1:0]  s2_jy_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_pop_reg    <= s1_pop_reg;
            prod_rest_reg <= PR_W'(rho_reg) * PR_W'($signed({1'b0, rest_coeff_reg}));
            prod_tcs_reg  <= PC_W'(rho_reg) * PC_W'($signed({1'b0, three_c2_reg}));
            s2_jx_reg     <= s1_jx_reg;
            s2_jy_reg     <= s1_jy_reg;
        end
    end

    // ---------------- stage 3: rest equilibrium, moving terms ----------------
    logic signed [RP_W-1:0]   rho_part;
    logic signed [T_W-1:0]    j3x;
    logic signed [T_W-1:0]    j3y;
    logic signed [T_W-1:0]    t_next [4];
    pop_t                     s3_pop_reg;
    logic signed [FEQ0_W-1:0] s3_feq0_reg;
    logic signed [T_W-1:0]    t_reg [4];

    // direction order for the moving arrays: east, north, west, south
    always_comb
    begin
        rho_part  = $signed(prod_tcs_reg[PC_W-1:FRAC_BITS]);
        j3x       = T_W'(s2_jx_reg) + (T_W'(s2_jx_reg) <<< 1);
        j3y       = T_W'(s2_jy_reg) + (T_W'(s2_jy_reg) <<< 1);
        t_next[0] = T_W'(rho_part) + j3x;
        t_next[1] = T_W'(rho_part) + j3y;
        t_next[2] = T_W'(rho_part) - j3x;
        t_next[3] = T_W'(rho_part) - j3y;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_pop_reg  <= s2_pop_reg;
            s3_feq0_reg <= $signed(prod_rest_reg[PR_W-1:FRAC_BITS]);
            for (int d = 0; d < 4; d++)
            begin
                t_reg[d] <= t_next[d];
            end
        end
    end

    // ---------------- stage 4: move weight products ----------------
    pop_t                     s4_pop_reg;
    logic signed [FEQ0_W-1:0] s4_feq0_reg;
    logic signed [PM_W-1:0]   prod_mw_reg [4];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_pop_reg  <= s3_pop_reg;
            s4_feq0_reg <= s3_feq0_reg;
            for (int d = 0; d < 4; d++)
            begin
                prod_mw_reg[d] <= PM_W'(t_reg[d]) * PM_W'($signed({1'b0, move_weight_reg}));
            end
        end
    end

    // ---------------- stages 5 and 6: relaxation lanes ----------------
    relax_en_t               rx_en;
    logic signed [FEQ_W-1:0] feq_rest;
    logic signed [FEQ_W-1:0] feq_mv [4];

    assign rx_en.mul = en[4];
    assign rx_en.sum = en[5];

    always_comb
    begin
        feq_rest = FEQ_W'(s4_feq0_reg);
        for (int d = 0; d < 4; d++)
        begin
            feq_mv[d] = $signed(prod_mw_reg[d][PM_W-1:FRAC_BITS]);
        end
    end

    d2q5_relax u_relax_rest (
        .clk         (clk),
        .en          (rx_en),
        .keep_factor (keep_factor_reg),
        .mix_factor  (mix_factor_reg),
        .f           (s4_pop_reg.pop_rest),
        .feq         (feq_rest),
        .post        (post.post_rest)
    );

    d2q5_relax u_relax_east (
        .clk         (clk),
        .en          (rx_en),
        .keep_factor (keep_factor_reg),
        .mix_factor  (mix_factor_reg),
        .f           (s4_pop_reg.pop_east),
        .feq         (feq_mv[0]),
        .post        (post.post_east)
    );

    d2q5_relax u_relax_north (
        .clk         (clk),
        .en          (rx_en),
        .keep_factor (keep_factor_reg),
        .mix_factor  (mix_factor_reg),
        .f           (s4_pop_reg.pop_north),
        .feq         (feq_mv[1]),
        .post        (post.post_north)
    );

    d2q5_relax u_relax_west (
        .clk         (clk),
        .en          (rx_en),
        .keep_factor (keep_factor_reg),
        .mix_factor  (mix_factor_reg),
        .f           (s4_pop_reg.pop_west),
        .feq         (feq_mv[2]),
        .post        (post.post_west)
    );

    d2q5_relax u_relax_south (
        .clk         (clk),
        .en          (rx_en),
        .keep_factor (keep_factor_reg),
        .mix_factor  (mix_factor_reg),
        .f           (s4_pop_reg.pop_south),
        .feq         (feq_mv[3]),
        .post        (post.post_south)
    );

    // ---------------- assertions ----------------
    // an accepted transfer always lands in stage 1
    `D2Q5_ASSERT_NEXT(a_accept_loads, pop_valid && pop_ready, vld_reg[0],
        "accepted cell did not enter stage 1")
    // a stalled output stage keeps its item and value
    `D2Q5_ASSERT_NEXT(a_out_stage_holds, post_valid && !post_ready,
        post_valid && $stable(post), "stalled output stage changed")
    // full pipe with a stalled sink must refuse input
    `D2Q5_ASSERT_SAME(a_full_blocks_input, (&vld_reg) && !post_ready, !pop_ready,
        "input accepted while every stage is full and stalled")

endmodule

### hw/rtl/d2q5_relax.sv
// One relaxation lane: keep*f + mix*feq, floor shift, saturate to 32 bits.
// Two register stages; depends on d2q5_pkg.
module d2q5_relax (
    input  logic                                   clk,
    input  d2q5_pkg::relax_en_t                    en,
    input  logic signed [d2q5_pkg::KEEP_W-1:0]     keep_factor,
    input  logic        [d2q5_pkg::MIX_W-1:0]      mix_factor,
    input  logic signed [d2q5_pkg::POP_W-1:0]      f,
    input  logic signed [d2q5_pkg::FEQ_W-1:0]      feq,
    output logic signed [d2q5_pkg::POP_W-1:0]      post
);
    import d2q5_pkg::*;

    logic signed [KF_W-1:0]  kf_reg;
    logic signed [KF_W-1:0]  kf_next;
    logic signed [MF_W-1:0]  mf_reg;
    logic signed [MF_W-1:0]  mf_next;
    logic signed [ACC_W-1:0] acc;
    logic        [R_W-1:0]   shifted;
    logic [R_W-POP_W:0]      hi_bits;
    logic signed [POP_W-1:0] post_reg;
    logic signed [POP_W-1:0] post_next;

    // products
    always_comb
    begin
        kf_next = KF_W'(keep_factor) * KF_W'(f);
        mf_next = MF_W'(feq) * MF_W'($signed({1'b0, mix_factor}));
    end

    // sum, floor, clamp
    always_comb
    begin
        acc     = ACC_W'(kf_reg) + ACC_W'(mf_reg);
        shifted = acc[ACC_W-1:FRAC_BITS];
        hi_bits = shifted[R_W-1:POP_W-1];
        priority if ((&hi_bits) || !(|hi_bits))
        begin
            post_next = $signed(shifted[POP_W-1:0]);
        end
        else if (shifted[R_W-1])
        begin
            post_next = $signed({1'b1, {(POP_W-1){1'b0}}});
        end
        else
        begin
            post_next = $signed({1'b0, {(POP_W-1){1'b1}}});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            kf_reg <= kf_next;
            mf_reg <= mf_next;
        end
        if (en.sum)
        begin
            post_reg <= post_next;
        end
    end

    assign post = post_reg;

endmodule

### test/testbench.sv
// Self-checking testbench for d2q5_lattice_collision, the D2Q5 BGK collision block.
// Depends on d2q5_pkg and the RTL under hw/rtl. Runs a directed table, part typed in, then
// several register settings of random cells; all else is checked by a local predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import d2q5_pkg::*;

    // ------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------
    localparam int NUM_PHASES   = 12;      // register settings after the directed table
    localparam int PHASE_CELLS  = 30;      // random cells per setting
    localparam int CALM_CELLS   = 60;      // last setting: no idling on either side
    localparam int MAX_BURST    = 11;      // longest idle burst, cycles
    localparam int SETTLE       = 10;      // pipeline is 6 deep, plus a margin
    localparam int CYCLE_LIMIT  = 200000;  // watchdog bound for the whole run

    // unmapped register indexes; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_LAST   = CFG_IDX_W'(7);

    // Q16.16 handy values
    localparam logic signed [POP_W-1:0] P_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POP_W-1:0] P_MIN = 32'sh8000_0000;
    localparam logic signed [POP_W-1:0] P_ONE = 32'sd65536;
    localparam longint LANE_MAX = 64'sd2147483647;
    localparam longint LANE_MIN = -64'sd2147483648;

    // register extremes, as written on the cfg bus
    localparam logic [CFG_DATA_W-1:0] KEEP_LOW  = CFG_DATA_W'(-65536);
    localparam logic [CFG_DATA_W-1:0] KEEP_HIGH = CFG_DATA_W'(65536);
    localparam logic [CFG_DATA_W-1:0] KEEP_MOST_NEG = 18'h2_0000;
    localparam logic [CFG_DATA_W-1:0] ALL_ONES  = 18'h3_FFFF;

    // ------------------------------------------------------------------
    // Directed table: cell in, and the output typed in where it is obvious
    // at reset defaults (zeros, tiny values, the two extremes). Other rows
    // go through the predictor.
    // ------------------------------------------------------------------
    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;
    localparam post_t NO_WANT = '0;

    typedef struct packed {
        pop_t  pops;
        bit    typed;
        post_t want;
    } cell_row_t;

    localparam int NUM_ROWS = 16;

    cell_row_t directed_rows [NUM_ROWS] = '{
        // all zero: nothing to relax
        '{'{0, 0, 0, 0, 0}, TYPED, '{0, 0, 0, 0, 0}},
        // rest = 2 ulp: feq0 = rho/2 = 1, moving feq rounds down to 0
        '{'{2, 0, 0, 0, 0}, TYPED, '{1, 0, 0, 0, 0}},
        // all max: rest saturates high, movers = floor(w * 0.75 * rho)
        '{'{P_MAX, P_MAX, P_MAX, P_MAX, P_MAX}, TYPED,
          '{P_MAX, 1342218239, 1342218239, 1342218239, 1342218239}},
        // all min: rest saturates low, movers exact
        '{'{P_MIN, P_MIN, P_MIN, P_MIN, P_MIN}, TYPED,
          '{P_MIN, -1342218240, -1342218240, -1342218240, -1342218240}},
        '{'{-1, -1, -1, -1, -1}, PREDICTED, NO_WANT},
        // unit momentum along each direction
        '{'{0, P_ONE, 0, 0, 0}, PREDICTED, NO_WANT},
        '{'{0, 0, P_ONE, 0, 0}, PREDICTED, NO_WANT},
        '{'{0, 0, 0, P_ONE, 0}, PREDICTED, NO_WANT},
        '{'{0, 0, 0, 0, P_ONE}, PREDICTED, NO_WANT},
        // largest |jx| and |jy|, both signs
        '{'{0, P_MAX, 0, P_MIN, 0}, PREDICTED, NO_WANT},
        '{'{0, 0, P_MIN, 0, P_MAX}, PREDICTED, NO_WANT},
        // uniform 0.2 per direction, near equilibrium
        '{'{13107, 13107, 13107, 13107, 13107}, PREDICTED, NO_WANT},
        '{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA},
          PREDICTED, NO_WANT},
        '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555},
          PREDICTED, NO_WANT},
        '{'{P_MIN, 0, 0, 0, 0}, PREDICTED, NO_WANT},
        '{'{P_MAX, P_MIN, P_MIN, P_MIN, P_MIN}, PREDICTED, NO_WANT}
    };

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  pop_valid;
    logic                  pop_ready;
    pop_t                  pop;
    logic                  post_valid;
    logic                  post_ready = 1'b0;
    post_t                 post;

    d2q5_lattice_collision u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop        (pop),
        .post_valid (post_valid),
        .post_ready (post_ready),
        .post       (post)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Shadow of the config registers, kept at the block's widths
    // ------------------------------------------------------------------
    logic [REST_W-1:0]        rest_reg;
    logic [MW_W-1:0]          weight_reg;
    logic [TCS_W-1:0]         tcs_reg;
    logic signed [KEEP_W-1:0] keep_reg;
    logic [MIX_W-1:0]         mix_reg;

    post_t expected_posts [$];   // relaxed cells still owed by the block

    int  cycle_count;
    int  mismatches = 0;
    int  cells_sent;
    int  posts_seen = 0;
    int  reg_writes;
    int  unmapped_writes;
    int  settings_used;
    int  sat_lanes;
    int  idle_pct;               // sender idle-burst chance, percent; receiver gets half
    bit  calm;                   // last stretch: both sides run flat out

    // ------------------------------------------------------------------
    // Collision predictor. All math in 64-bit signed; >>> is floor.
    // ------------------------------------------------------------------
    function automatic logic signed [POP_W-1:0] relax_lane(longint f, longint feq);
        longint acc;
        acc = longint'(keep_reg) * f + longint'(mix_reg) * feq;
        acc = acc >>> FRAC_BITS;
        if (acc > LANE_MAX || acc < LANE_MIN)
            sat_lanes++;
        if (acc > LANE_MAX)
            acc = LANE_MAX;
        if (acc < LANE_MIN)
            acc = LANE_MIN;
        return POP_W'(acc);
    endfunction

    // weight * (three_c2*rho term + 3*j), floored
    function automatic longint moving_feq(longint rho_part, longint j);
        return (longint'(weight_reg) * (rho_part + 3 * j)) >>> FRAC_BITS;
    endfunction

    function automatic post_t collide(pop_t pops);
        longint f0, fe, fn, fw, fs;
        longint rho, jx, jy, feq0, rho_part;
        post_t  r;
        f0 = pops.pop_rest;
        fe = pops.pop_east;
        fn = pops.pop_north;
        fw = pops.pop_west;
        fs = pops.pop_south;
        rho = f0 + fe + fn + fw + fs;
        jx  = fe - fw;
        jy  = fn - fs;
        feq0     = (longint'(rest_reg) * rho) >>> FRAC_BITS;
        rho_part = (longint'(tcs_reg) * rho) >>> FRAC_BITS;
        r.post_rest  = relax_lane(f0, feq0);
        r.post_east  = relax_lane(fe, moving_feq(rho_part, jx));
        r.post_north = relax_lane(fn, moving_feq(rho_part, jy));
        r.post_west  = relax_lane(fw, moving_feq(rho_part, -jx));
        r.post_south = relax_lane(fs, moving_feq(rho_part, -jy));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random cells: full-range noise, physical densities around 1.0,
    // small signed values, and lanes pinned to extremes.
    // ------------------------------------------------------------------
    function automatic logic signed [POP_W-1:0] random_lane(int unsigned kind);
        logic signed [POP_W-1:0] v;
        case (kind)
            0: v = $urandom;
            1: v = $urandom_range(0, 2 * 65536);
            2: v = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            default:
            begin
                case ($urandom_range(0, 7))
                    0: v = P_MAX;
                    1: v = P_MIN;
                    2: v = 0;
                    3: v = -1;
                    4: v = P_ONE;
                    5: v = -P_ONE;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic pop_t random_cell();
        int unsigned kind;
        pop_t pops;
        kind = $urandom_range(0, 3);
        pops.pop_rest  = random_lane(kind);
        pops.pop_east  = random_lane(kind);
        pops.pop_north = random_lane(kind);
        pops.pop_west  = random_lane(kind);
        pops.pop_south = random_lane(kind);
        return pops;
    endfunction

    // Register value: an extreme, raw bus bits, or in range.
    function automatic logic [CFG_DATA_W-1:0] random_reg_value(logic [CFG_IDX_W-1:0] idx);
        int span;
        logic [CFG_DATA_W-1:0] v;
        span = (idx == REG_THREE_C2) ? 196608 : (idx == REG_MIX_FACTOR) ? 131072 : 65536;
        case ($urandom_range(0, 4))
            0: v = (idx == REG_KEEP_FACTOR) ? KEEP_LOW : '0;
            1: v = (idx == REG_KEEP_FACTOR) ? KEEP_HIGH : CFG_DATA_W'(span);
            2: v = CFG_DATA_W'($urandom);
            default:
            begin
                if (idx == REG_KEEP_FACTOR)
                    v = CFG_DATA_W'(int'($urandom_range(0, 131072)) - 65536);
                else
                    v = CFG_DATA_W'($urandom_range(0, span));
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Inputs change on the falling edge; transfers are seen on
    // the rising edge. Valid is left high on return so back-to-back
    // transfers never drop it; callers lower it when a batch ends.
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        // mirror the write; unmapped indexes are dropped
        case (idx)
            REG_REST_COEFF:  rest_reg   = data[REST_W-1:0];
            REG_MOVE_WEIGHT: weight_reg = data[MW_W-1:0];
            REG_THREE_C2:    tcs_reg    = data[TCS_W-1:0];
            REG_KEEP_FACTOR: keep_reg   = data[KEEP_W-1:0];
            REG_MIX_FACTOR:  mix_reg    = data[MIX_W-1:0];
            default:         unmapped_writes++;
        endcase
        reg_writes++;
        @(negedge clk);
    endtask

    task automatic send_cell(pop_t pops, bit typed, post_t want);
        if (!calm && $urandom_range(0, 99) < idle_pct)
        begin
            pop_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_BURST)) @(negedge clk);
        end
        pop_valid <= 1'b1;
        pop       <= pops;
        do
            @(posedge clk);
        while (!pop_ready);
        expected_posts.push_back(typed ? want : collide(pops));
        cells_sent++;
        @(negedge clk);
    endtask

    // Stop the sender and wait out the pipeline so config can change.
    task automatic drain();
        pop_valid <= 1'b0;
        while (expected_posts.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, none when calm
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (calm)
        begin
            stall_left = 0;
            post_ready <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            post_ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < idle_pct / 2)
        begin
            stall_left = $urandom_range(0, MAX_BURST - 1);
            post_ready <= 1'b0;
        end
        else
            post_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Output check: each post transfer against the oldest expectation
    // ------------------------------------------------------------------
    task automatic check_lane(string lane, logic signed [POP_W-1:0] want,
                              logic signed [POP_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", lane, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : post_check
        post_t want;
        if (rst_n && post_valid && post_ready)
        begin
            posts_seen++;
            if (expected_posts.size() == 0)
            begin
                $error("post transfer with nothing outstanding: %h", post);
                mismatches++;
            end
            else
            begin
                want = expected_posts.pop_front();
                check_lane("post_rest",  want.post_rest,  post.post_rest);
                check_lane("post_east",  want.post_east,  post.post_east);
                check_lane("post_north", want.post_north, post.post_north);
                check_lane("post_west",  want.post_west,  post.post_west);
                check_lane("post_south", want.post_south, post.post_south);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_posts.size());
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int n_cells;
        logic [CFG_DATA_W-1:0] mix_val;

        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        pop_valid  = 1'b0;
        pop        = '0;
        cells_sent = 0;
        reg_writes = 0;
        unmapped_writes = 0;
        sat_lanes  = 0;
        calm       = 1'b0;
        idle_pct   = 20;
        settings_used = 1;

        // defaults the block comes out of reset with
        rest_reg   = REST_COEFF_RST;
        weight_reg = MOVE_WEIGHT_RST;
        tcs_reg    = THREE_C2_RST;
        keep_reg   = KEEP_FACTOR_RST;
        mix_reg    = MIX_FACTOR_RST;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table at reset defaults. Typed rows rely on those defaults.
        for (int i = 0; i < NUM_ROWS; i++)
            send_cell(directed_rows[i].pops, directed_rows[i].typed, directed_rows[i].want);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            // pipeline must be empty before any register moves
            drain();
            calm = (phase == NUM_PHASES - 1);
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 40;
            endcase

            case (phase)
                0:
                begin
                    // everything at its low end: output is -f, MIN saturates high
                    write_reg(REG_REST_COEFF, '0);
                    write_reg(REG_MOVE_WEIGHT, '0);
                    write_reg(REG_THREE_C2, '0);
                    write_reg(REG_KEEP_FACTOR, KEEP_LOW);
                    write_reg(REG_MIX_FACTOR, '0);
                end
                1:
                begin
                    write_reg(REG_REST_COEFF, CFG_DATA_W'(65536));
                    write_reg(REG_MOVE_WEIGHT, CFG_DATA_W'(65536));
                    write_reg(REG_THREE_C2, CFG_DATA_W'(196608));
                    write_reg(REG_KEEP_FACTOR, KEEP_HIGH);
                    write_reg(REG_MIX_FACTOR, CFG_DATA_W'(131072));
                end
                2:
                begin
                    // all bus bits set: 17-bit regs must drop bit 17, keep reads as -1
                    write_reg(REG_REST_COEFF, ALL_ONES);
                    write_reg(REG_MOVE_WEIGHT, ALL_ONES);
                    write_reg(REG_THREE_C2, ALL_ONES);
                    write_reg(REG_KEEP_FACTOR, ALL_ONES);
                    write_reg(REG_MIX_FACTOR, ALL_ONES);
                    write_reg(REG_INDEX_LAST, '0);
                end
                3:
                begin
                    // most negative keep the field can hold, mix at full width
                    write_reg(REG_REST_COEFF, CFG_DATA_W'(REST_COEFF_RST));
                    write_reg(REG_MOVE_WEIGHT, CFG_DATA_W'(MOVE_WEIGHT_RST));
                    write_reg(REG_THREE_C2, CFG_DATA_W'(THREE_C2_RST));
                    write_reg(REG_KEEP_FACTOR, KEEP_MOST_NEG);
                    write_reg(REG_MIX_FACTOR, ALL_ONES);
                    write_reg(REG_UNUSED_FIRST, ALL_ONES);
                end
                4:
                begin
                    // a physical relaxation: keep = 1 - 1/tau, tau in [0.5, 2]
                    mix_val = CFG_DATA_W'($urandom_range(32768, 131072));
                    write_reg(REG_REST_COEFF, CFG_DATA_W'(REST_COEFF_RST));
                    write_reg(REG_MOVE_WEIGHT, CFG_DATA_W'(MOVE_WEIGHT_RST));
                    write_reg(REG_THREE_C2, CFG_DATA_W'(THREE_C2_RST));
                    write_reg(REG_MIX_FACTOR, mix_val);
                    write_reg(REG_KEEP_FACTOR, CFG_DATA_W'(65536 - int'(mix_val)));
                end
                default:
                begin
                    for (int r = REG_REST_COEFF; r <= REG_MIX_FACTOR; r++)
                        write_reg(CFG_IDX_W'(r), random_reg_value(CFG_IDX_W'(r)));
                    // stray writes to unmapped indexes must not disturb anything
                    if ($urandom_range(0, 1) == 1)
                        write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_INDEX_LAST)),
                                  CFG_DATA_W'($urandom));
                end
            endcase
            cfg_valid <= 1'b0;
            @(negedge clk);
            settings_used++;

            n_cells = calm ? CALM_CELLS : PHASE_CELLS;
            for (int i = 0; i < n_cells; i++)
                send_cell(random_cell(), PREDICTED, NO_WANT);
        end

        pop_valid <= 1'b0;
        while (expected_posts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Ran %0d cells under %0d register settings, %0d config writes (%0d unmapped).",
                 cells_sent, settings_used, reg_writes, unmapped_writes);
        $display("%0d results checked, %0d lanes predicted saturated, %0d mismatches.",
                 posts_seen, sat_lanes, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
